// ----- rtl/qrs_pkg.sv -----
// Shared types and codes for the quadratic root solver.
package qrs_pkg;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic sa;
    logic sb;
    logic sc;
    logic az;
    logic bz;
    logic cz;
    logic neg_d;
  } qrs_flags_t;

endpackage

// ----- rtl/qrs_disc.sv -----
// Three-stage magnitude, product and discriminant front end.
module qrs_disc #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] c_i,
  output logic                valid_o,
  output logic [2*W+1:0]      d_o,
  output logic [W-1:0]        ma_o,
  output logic [W-1:0]        mb_o,
  output logic [W-1:0]        mc_o,
  output qrs_pkg::qrs_flags_t flags_o
);
  import qrs_pkg::*;

  logic [W-1:0] ma1_q, mb1_q, mc1_q, ma2_q, mb2_q, mc2_q;
  qrs_flags_t fl1_q, fl2_q, fl3_q, fl1_d, fl3_d;
  logic [2*W-1:0] bb_q, ac_q;
  logic [2*W+1:0] d_q, d_d, bbx, ac4;
  logic [W-1:0] ma3_q, mb3_q, mc3_q;
  logic v1_q, v2_q, v3_q;
  logic same;

  always_comb begin
    fl1_d       = '0;
    fl1_d.sa    = a_i[W-1];
    fl1_d.sb    = b_i[W-1];
    fl1_d.sc    = c_i[W-1];
    fl1_d.az    = (a_i == '0);
    fl1_d.bz    = (b_i == '0);
    fl1_d.cz    = (c_i == '0);
  end

  always_comb begin
    bbx   = {2'b00, bb_q};
    ac4   = {ac_q, 2'b00};
    same  = !fl2_q.cz && (fl2_q.sa == fl2_q.sc);
    fl3_d = fl2_q;
    fl3_d.neg_d = same && (bbx < ac4);
    d_d   = same ? (bbx - ac4) : (bbx + ac4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma1_q <= a_i[W-1] ? (~a_i + 1'b1) : a_i;
      mb1_q <= b_i[W-1] ? (~b_i + 1'b1) : b_i;
      mc1_q <= c_i[W-1] ? (~c_i + 1'b1) : c_i;
      fl1_q <= fl1_d;
      bb_q  <= (2*W)'(mb1_q) * (2*W)'(mb1_q);
      ac_q  <= (2*W)'(ma1_q) * (2*W)'(mc1_q);
      ma2_q <= ma1_q;
      mb2_q <= mb1_q;
      mc2_q <= mc1_q;
      fl2_q <= fl1_q;
      d_q   <= d_d;
      fl3_q <= fl3_d;
      ma3_q <= ma2_q;
      mb3_q <= mb2_q;
      mc3_q <= mc2_q;
    end
  end

  assign valid_o = v3_q;
  assign d_o     = d_q;
  assign ma_o    = ma3_q;
  assign mb_o    = mb3_q;
  assign mc_o    = mc3_q;
  assign flags_o = fl3_q;
endmodule

// ----- rtl/qrs_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module qrs_sqrt #(
  parameter int SW    = 33,
  parameter int TAG_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [SW-1:0]     root_o,
  output logic [TAG_W-1:0]  tag_o
);
  localparam int DW = 2 * SW;

  logic [SW:0]      rem  [0:SW];
  logic [SW-1:0]    root [0:SW];
  logic [DW-1:0]    rad  [0:SW];
  logic [TAG_W-1:0] tag  [0:SW];
  logic             vld  [0:SW];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_i;
  assign tag[0]  = tag_i;
  assign vld[0]  = valid_i;

  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [SW+2:0] rs, trial;
    logic [SW:0]   rem_d;
    logic [SW-1:0] root_d;
    always_comb begin
      rs    = {rem[g], rad[g][DW-1 -: 2]};
      trial = {1'b0, root[g], 2'b01};
      if (rs >= trial) begin
        rem_d  = rs[SW:0] - trial[SW:0];
        root_d = {root[g][SW-2:0], 1'b1};
      end else begin
        rem_d  = rs[SW:0];
        root_d = {root[g][SW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[g+1] <= 1'b0;
      end else if (en_i) begin
        vld[g+1] <= vld[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[g+1]  <= rem_d;
        root[g+1] <= root_d;
        rad[g+1]  <= {rad[g][DW-3:0], 2'b00};
        tag[g+1]  <= tag[g];
      end
    end
  end

  assign valid_o = vld[SW];
  assign root_o  = root[SW];
  assign tag_o   = tag[SW];
endmodule

// ----- rtl/qrs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div #(
  parameter int NW    = 34,
  parameter int DNW   = 33,
  parameter int F     = 16,
  parameter int TAG_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DNW-1:0]    den_i,
  input  logic              neg_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [NW+F-1:0]   quo_o,
  output logic              neg_o,
  output logic [TAG_W-1:0]  tag_o
);
  localparam int QW = NW + F;

  logic [DNW-1:0]   rem [0:QW];
  logic [QW-1:0]    dvd [0:QW];
  logic [QW-1:0]    quo [0:QW];
  logic [DNW-1:0]   den [0:QW];
  logic             neg [0:QW];
  logic [TAG_W-1:0] tag [0:QW];
  logic             vld [0:QW];

  assign rem[0] = '0;
  assign dvd[0] = {num_i, {F{1'b0}}};
  assign quo[0] = '0;
  assign den[0] = den_i;
  assign neg[0] = neg_i;
  assign tag[0] = tag_i;
  assign vld[0] = valid_i;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DNW:0]   rs;
    logic [DNW-1:0] rem_d;
    logic           qbit;
    always_comb begin
      rs = {rem[g], dvd[g][QW-1]};
      if (rs >= {1'b0, den[g]}) begin
        rem_d = rs[DNW-1:0] - den[g];
        qbit  = 1'b1;
      end else begin
        rem_d = rs[DNW-1:0];
        qbit  = 1'b0;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[g+1] <= 1'b0;
      end else if (en_i) begin
        vld[g+1] <= vld[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[g+1] <= rem_d;
        dvd[g+1] <= {dvd[g][QW-2:0], 1'b0};
        quo[g+1] <= {quo[g][QW-2:0], qbit};
        den[g+1] <= den[g];
        neg[g+1] <= neg[g];
        tag[g+1] <= tag[g];
      end
    end
  end

  assign valid_o = vld[QW];
  assign quo_o   = quo[QW];
  assign neg_o   = neg[QW];
  assign tag_o   = tag[QW];
endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Top level of the pipelined quadratic root solver.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o   | coef_a_i, coef_b_i, coef_c_i
//  out     | out_valid_o / out_ready_i | root_count_o, root_first_o, root_second_o,
//          |                           | degenerate_o, saturated_o
//
// One item enters per cycle while the output is not stalled. The square root
// and the two dividers (W = COEF_WIDTH, F = FRAC_BITS) resolve one bit per stage.
// Reset clears every stage valid bit, the output valid included.
// When the output holds an item that is not taken, the whole pipeline holds;
// in_ready_o is low only then, so no item is lost or repeated.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   root_count_o,
  output logic signed [COEF_WIDTH-1:0] root_first_o,
  output logic signed [COEF_WIDTH-1:0] root_second_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);
  import qrs_pkg::*;

  localparam int W     = COEF_WIDTH;
  localparam int SW    = W + 1;      // square root width
  localparam int NW    = W + 2;      // numerator magnitude width
  localparam int DNW   = W + 1;      // denominator width
  localparam int QW    = NW + FRAC_BITS;
  localparam int FL_W  = $bits(qrs_flags_t);
  localparam int STAG  = FL_W + 3 * W + 1;
  localparam int CTL_W = 4;          // count, degenerate, second root used
  localparam logic [QW-1:0] LIM_POS = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = LIM_POS + 1'b1;

  logic adv;
  logic out_valid_q;

  // Everything moves together unless a finished item is stuck at the output.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Front end: magnitudes, b*b and a*c, then the exact discriminant.
  logic           dv;
  logic [2*W+1:0] d;
  logic [W-1:0]   ma, mb, mc;
  qrs_flags_t     fl;

  qrs_disc #(.W(W)) u_disc (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i),
    .a_i(coef_a_i), .b_i(coef_b_i), .c_i(coef_c_i),
    .valid_o(dv), .d_o(d), .ma_o(ma), .mb_o(mb), .mc_o(mc), .flags_o(fl)
  );

  // Square root of the discriminant; the coefficients ride along as a tag.
  logic            sv;
  logic [SW-1:0]   s;
  logic [STAG-1:0] stag;

  qrs_sqrt #(.SW(SW), .TAG_W(STAG)) u_sqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv), .rad_i(d),
    .tag_i({fl, ma, mb, mc, (d == '0)}),
    .valid_o(sv), .root_o(s), .tag_o(stag)
  );

  qrs_flags_t   sfl;
  logic [W-1:0] sma, smb, smc;
  logic         sdz;
  assign {sfl, sma, smb, smc, sdz} = stag;

  // Setup stage: pick the case, form numerators and the shared denominator.
  logic signed [NW:0] nbs, ss, n1, n2;
  logic [NW-1:0]      num1_d, num2_d, num1_q, num2_q;
  logic [DNW-1:0]     den_d, den_q;
  logic               neg1_d, neg2_d, neg1_q, neg2_q, nneg1;
  logic [1:0]         cnt_d;
  logic               deg_d, use2_d;
  logic [CTL_W-1:0]   ctl_q;
  logic               setup_v_q;

  always_comb begin
    nbs    = sfl.sb ? $signed({3'b000, smb}) : -$signed({3'b000, smb});
    ss     = $signed({2'b00, s});
    n1     = nbs + ss;
    n2     = nbs - ss;
    cnt_d  = CNT_NONE;
    deg_d  = 1'b0;
    use2_d = 1'b0;
    num1_d = '0;
    num2_d = '0;
    nneg1  = 1'b0;
    den_d  = {{(DNW-1){1'b0}}, 1'b1};
    neg1_d = 1'b0;
    neg2_d = 1'b0;
    if (sfl.az && sfl.bz) begin
      deg_d = 1'b1;
    end else if (sfl.az) begin
      // Linear equation: -c / b.
      cnt_d  = CNT_ONE;
      num1_d = {2'b00, smc};
      nneg1  = !sfl.sc && !sfl.cz;
      den_d  = {1'b0, smb};
      neg1_d = nneg1 ^ sfl.sb;
    end else if (sfl.neg_d) begin
      cnt_d = CNT_NONE;
    end else if (sdz) begin
      // Double root: -b / 2a.
      cnt_d  = CNT_ONE;
      num1_d = {2'b00, smb};
      nneg1  = !sfl.sb && !sfl.bz;
      den_d  = {sma, 1'b0};
      neg1_d = nneg1 ^ sfl.sa;
    end else begin
      cnt_d  = CNT_TWO;
      use2_d = 1'b1;
      num1_d = n1[NW] ? NW'(-n1) : n1[NW-1:0];
      num2_d = n2[NW] ? NW'(-n2) : n2[NW-1:0];
      den_d  = {sma, 1'b0};
      neg1_d = n1[NW] ^ sfl.sa;
      neg2_d = n2[NW] ^ sfl.sa;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_v_q <= 1'b0;
    end else if (adv) begin
      setup_v_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num1_q <= num1_d;
      num2_q <= num2_d;
      den_q  <= den_d;
      neg1_q <= neg1_d;
      neg2_q <= neg2_d;
      ctl_q  <= {cnt_d, deg_d, use2_d};
    end
  end

  // Two dividers in lockstep, one per root.
  logic             qv1, qv2_unused_v, qn1, qn2;
  logic [QW-1:0]    q1, q2;
  logic [CTL_W-1:0] qctl;
  logic             qtag2;

  qrs_div #(.NW(NW), .DNW(DNW), .F(FRAC_BITS), .TAG_W(CTL_W)) u_div_first (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(setup_v_q),
    .num_i(num1_q), .den_i(den_q), .neg_i(neg1_q), .tag_i(ctl_q),
    .valid_o(qv1), .quo_o(q1), .neg_o(qn1), .tag_o(qctl)
  );

  qrs_div #(.NW(NW), .DNW(DNW), .F(FRAC_BITS), .TAG_W(1)) u_div_second (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(setup_v_q),
    .num_i(num2_q), .den_i(den_q), .neg_i(neg2_q), .tag_i(ctl_q[0]),
    .valid_o(qv2_unused_v), .quo_o(q2), .neg_o(qn2), .tag_o(qtag2)
  );

  // Output stage: clip to the signed range, apply the sign, hold for the sink.
  logic [QW-1:0] lim1, lim2, c1, c2;
  logic          clip1, clip2, use1, use2;
  logic [1:0]    cnt_out;
  logic [W-1:0]  r1_d, r2_d, r1_q, r2_q;
  logic [1:0]    cnt_q;
  logic          deg_q, sat_q, sat_d;

  always_comb begin
    cnt_out = qctl[3:2];
    use1    = (cnt_out != CNT_NONE);
    use2    = qtag2 && qv2_unused_v;
    lim1    = qn1 ? LIM_NEG : LIM_POS;
    lim2    = qn2 ? LIM_NEG : LIM_POS;
    clip1   = q1 > lim1;
    clip2   = q2 > lim2;
    c1      = clip1 ? lim1 : q1;
    c2      = clip2 ? lim2 : q2;
    r1_d    = '0;
    r2_d    = '0;
    if (use1) begin
      r1_d = qn1 ? (~c1[W-1:0] + 1'b1) : c1[W-1:0];
    end
    if (use2) begin
      r2_d = qn2 ? (~c2[W-1:0] + 1'b1) : c2[W-1:0];
    end
    sat_d = (use1 && clip1) || (use2 && clip2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= qv1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q <= cnt_out;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      deg_q <= qctl[1];
      sat_q <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign root_count_o  = cnt_q;
  assign root_first_o  = r1_q;
  assign root_second_o = r2_q;
  assign degenerate_o  = deg_q;
  assign saturated_o   = sat_q;
endmodule
